// File: hw/rtl/ptw_pkg.sv
package ptw_pkg;

   localparam int VaWidth    = 48;
   localparam int EntryWidth = 32;
   localparam int AddrWidth  = 32;
   localparam int IndexWidth = 9;

   localparam logic OP_START    = 1'b0;
   localparam logic OP_RESPONSE = 1'b1;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   localparam logic [1:0] LEVEL_PML4 = 2'd0;
   localparam logic [1:0] LEVEL_PDPT = 2'd1;
   localparam logic [1:0] LEVEL_PD   = 2'd2;
   localparam logic [1:0] LEVEL_PT   = 2'd3;

   localparam int LargePageBit = 7;

   typedef struct packed {
      logic                  opcode;
      logic [VaWidth-1:0]    virtual_address;
      logic [EntryWidth-1:0] entry_data;
   } item_type;

   typedef struct packed {
      logic                 valid;
      logic                 kind;
      logic [AddrWidth-1:0] address;
   } result_type;

   typedef struct packed {
      logic       busy;
      logic [1:0] level;
   } status_type;

   function automatic logic [AddrWidth-1:0] entry_addr(
      input logic [EntryWidth-1:0] frame,
      input logic [IndexWidth-1:0] idx
   );
      return {frame[31:12], idx, 3'b000};
   endfunction

endpackage

// File: hw/rtl/ptw_input_stage.sv
module ptw_input_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              advance,
   input  ptw_pkg::item_type item,
   output logic              stage_valid,
   output ptw_pkg::item_type stage_item
);

   logic              valid_ff;
   logic              valid_in;
   ptw_pkg::item_type item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;

endmodule

// File: hw/rtl/ptw_walk_core.sv
module ptw_walk_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [31:0]              csr_write_data,
   input  logic                     stage_valid,
   input  ptw_pkg::item_type        stage_item,
   input  logic                     advance,
   output ptw_pkg::result_type      result,
   output ptw_pkg::status_type      status
);

   logic [31:0] table_base_ff;
   logic [47:0] saved_address_ff;
   logic [47:0] saved_address_in;
   logic [1:0]  walk_level_ff;
   logic [1:0]  walk_level_in;
   logic        walk_busy_ff;
   logic        walk_busy_in;
   ptw_pkg::result_type res;

   always_comb begin
      saved_address_in = saved_address_ff;
      walk_level_in    = walk_level_ff;
      walk_busy_in     = walk_busy_ff;
      res.valid        = 1'b0;
      res.kind         = ptw_pkg::KIND_READ;
      res.address      = '0;
      if (stage_valid) begin
         if (stage_item.opcode == ptw_pkg::OP_START) begin
            if (!walk_busy_ff) begin
               saved_address_in = stage_item.virtual_address;
               walk_level_in    = ptw_pkg::LEVEL_PML4;
               walk_busy_in     = 1'b1;
               res.valid        = 1'b1;
               res.address      = ptw_pkg::entry_addr(table_base_ff,
                                     stage_item.virtual_address[47:39]);
            end
         end else if (walk_busy_ff) begin
            res.valid = 1'b1;
            unique case (walk_level_ff)
               ptw_pkg::LEVEL_PML4: begin
                  walk_level_in = ptw_pkg::LEVEL_PDPT;
                  res.address   = ptw_pkg::entry_addr(stage_item.entry_data,
                                     saved_address_ff[38:30]);
               end
               ptw_pkg::LEVEL_PDPT: begin
                  walk_level_in = ptw_pkg::LEVEL_PD;
                  res.address   = ptw_pkg::entry_addr(stage_item.entry_data,
                                     saved_address_ff[29:21]);
               end
               ptw_pkg::LEVEL_PD: begin
                  if (stage_item.entry_data[ptw_pkg::LargePageBit]) begin
                     walk_level_in = ptw_pkg::LEVEL_PML4;
                     walk_busy_in  = 1'b0;
                     res.kind      = ptw_pkg::KIND_DONE;
                     res.address   = {stage_item.entry_data[31:21],
                                      saved_address_ff[20:0]};
                  end else begin
                     walk_level_in = ptw_pkg::LEVEL_PT;
                     res.address   = ptw_pkg::entry_addr(stage_item.entry_data,
                                        saved_address_ff[20:12]);
                  end
               end
               default: begin
                  walk_level_in = ptw_pkg::LEVEL_PML4;
                  walk_busy_in  = 1'b0;
                  res.kind      = ptw_pkg::KIND_DONE;
                  res.address   = {stage_item.entry_data[31:12],
                                   saved_address_ff[11:0]};
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_base_ff    <= '0;
         saved_address_ff <= '0;
         walk_level_ff    <= ptw_pkg::LEVEL_PML4;
         walk_busy_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            table_base_ff <= csr_write_data;
         end
         if (advance) begin
            saved_address_ff <= saved_address_in;
            walk_level_ff    <= walk_level_in;
            walk_busy_ff     <= walk_busy_in;
         end
      end
   end

   assign result       = res;
   assign status.busy  = walk_busy_ff;
   assign status.level = walk_level_ff;

endmodule

// File: hw/rtl/ptw_output_stage.sv
module ptw_output_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  ptw_pkg::result_type result,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic                rsp_result_kind,
   output logic [31:0]         rsp_address
);

   logic        valid_ff;
   logic        valid_in;
   logic        load;
   logic        kind_ff;
   logic [31:0] address_ff;

   assign load = advance && result.valid;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff    <= result.kind;
         address_ff <= result.address;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_address     = address_ff;

endmodule

// File: hw/rtl/page_table_walker.sv
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   opcode, virtual_address, entry_data
// rsp_      out        rsp_valid/rsp_stall   result_kind, address
// csr_      in         csr_write_enable      write_data (table base)
//
// An item passes through an input register and then a result register, and
// one item is taken every cycle unless a stalled result is held.
// Items that cause no result still pass through the input register.
// Synchronous active-high reset empties both registers and leaves the walker idle.
// A stall on the result side holds the result register and, once the input
// register is full, raises req_stall in the same cycle.
module page_table_walker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [47:0] req_virtual_address,
   input  logic [31:0] req_entry_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_result_kind,
   output logic [31:0] rsp_address,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   ptw_pkg::item_type   req_item;
   ptw_pkg::item_type   stage_item;
   ptw_pkg::result_type result;
   ptw_pkg::status_type status;
   logic                stage_valid;
   logic                advance;
   logic                accept;

   assign req_item.opcode          = req_opcode;
   assign req_item.virtual_address = req_virtual_address;
   assign req_item.entry_data      = req_entry_data;

   assign advance   = stage_valid && (!rsp_valid || !rsp_stall);
   assign req_stall = stage_valid && !advance;
   assign accept    = req_valid && !req_stall;

   ptw_input_stage u_input (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .advance     (advance),
      .item        (req_item),
      .stage_valid (stage_valid),
      .stage_item  (stage_item)
   );

   ptw_walk_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .stage_valid      (stage_valid),
      .stage_item       (stage_item),
      .advance          (advance),
      .result           (result),
      .status           (status)
   );

   ptw_output_stage u_output (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .result          (result),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_result_kind (rsp_result_kind),
      .rsp_address     (rsp_address)
   );

`ifndef SYNTHESIS
   // An idle walker always waits at the top level.
   assert property (@(posedge clock) disable iff (reset)
      !status.busy |-> status.level == ptw_pkg::LEVEL_PML4)
      else $error("idle walker not at top level");

   // A finished translation leaves the walker idle.
   assert property (@(posedge clock) disable iff (reset)
      advance && result.valid && result.kind == ptw_pkg::KIND_DONE |=> !status.busy)
      else $error("walker still busy after finishing");

   // A start moves the walker to busy at the top level.
   assert property (@(posedge clock) disable iff (reset)
      advance && result.valid && stage_item.opcode == ptw_pkg::OP_START
      |=> status.busy && status.level == ptw_pkg::LEVEL_PML4)
      else $error("start did not begin a walk");

   // The input side stalls only behind a held item.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> stage_valid && rsp_valid)
      else $error("stall without a held item");
`endif

endmodule

// File: test/page_table_walker_test.sv
`timescale 1ns / 1ps

module page_table_walker_test;

   localparam int QuietLimit = 3000;
   localparam int HoldCycles = 300;
   localparam int IdlePercent = 32;

   typedef struct packed {
      logic                          kind;
      logic [ptw_pkg::AddrWidth-1:0] address;
   } walk_result_type;

   class walk_scoreboard;
      logic [31:0]       table_base;
      logic [47:0]       walk_va;
      logic [1:0]        walk_level;
      bit                walk_busy;
      walk_result_type   pending_results[$];
      int unsigned       mismatches;
      int unsigned       reads_issued;
      int unsigned       small_pages;
      int unsigned       large_pages;
      int unsigned       ignored_items;

      function new();
         table_base = '0;
         walk_va = '0;
         walk_level = ptw_pkg::LEVEL_PML4;
         walk_busy = 1'b0;
      endfunction

      function logic [31:0] read_address(logic [31:0] frame, logic [8:0] idx);
         return {frame[31:12], 12'h000} + {20'h00000, idx, 3'b000};
      endfunction

      function void push_result(logic kind, logic [31:0] address);
         walk_result_type r;
         r.kind = kind;
         r.address = address;
         pending_results.push_back(r);
         if (kind == ptw_pkg::KIND_READ) begin
            reads_issued++;
         end
      endfunction

      function void advance_walk(logic op, logic [47:0] va, logic [31:0] entry);
         if (op == ptw_pkg::OP_START) begin
            if (walk_busy) begin
               ignored_items++;
               return;
            end
            walk_va = va;
            walk_level = ptw_pkg::LEVEL_PML4;
            walk_busy = 1'b1;
            push_result(ptw_pkg::KIND_READ, read_address(table_base, va[47:39]));
            return;
         end
         if (!walk_busy) begin
            ignored_items++;
            return;
         end
         case (walk_level)
            ptw_pkg::LEVEL_PML4: begin
               walk_level = ptw_pkg::LEVEL_PDPT;
               push_result(ptw_pkg::KIND_READ, read_address(entry, walk_va[38:30]));
            end
            ptw_pkg::LEVEL_PDPT: begin
               walk_level = ptw_pkg::LEVEL_PD;
               push_result(ptw_pkg::KIND_READ, read_address(entry, walk_va[29:21]));
            end
            ptw_pkg::LEVEL_PD: begin
               if (entry[ptw_pkg::LargePageBit]) begin
                  walk_level = ptw_pkg::LEVEL_PML4;
                  walk_busy = 1'b0;
                  large_pages++;
                  push_result(ptw_pkg::KIND_DONE,
                              {entry[31:21], 21'h0} + {11'h0, walk_va[20:0]});
               end else begin
                  walk_level = ptw_pkg::LEVEL_PT;
                  push_result(ptw_pkg::KIND_READ, read_address(entry, walk_va[20:12]));
               end
            end
            default: begin
               walk_level = ptw_pkg::LEVEL_PML4;
               walk_busy = 1'b0;
               small_pages++;
               push_result(ptw_pkg::KIND_DONE,
                           {entry[31:12], 12'h000} + {20'h0, walk_va[11:0]});
            end
         endcase
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("%0t mismatch: %s", $realtime, msg);
      endtask

      task check_result(logic kind, logic [31:0] address);
         walk_result_type want;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d address %08h",
                                      kind, address));
            return;
         end
         want = pending_results.pop_front();
         if (kind !== want.kind) begin
            report_mismatch($sformatf("result_kind %0d, expected %0d", kind, want.kind));
         end
         if (address !== want.address) begin
            report_mismatch($sformatf("address %08h, expected %08h", address, want.address));
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_opcode;
   logic [47:0] req_virtual_address;
   logic [31:0] req_entry_data;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_result_kind;
   logic [31:0] rsp_address;
   logic        csr_write_enable;
   logic [31:0] csr_write_data;

   walk_scoreboard sb = new();
   bit no_idle = 1'b0;
   bit hold_off_request = 1'b0;

   page_table_walker dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_virtual_address (req_virtual_address),
      .req_entry_data      (req_entry_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_address         (rsp_address),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic send_item(input logic op, input logic [47:0] va, input logic [31:0] entry);
      while (!no_idle && $urandom_range(99) < IdlePercent) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_virtual_address <= va;
      req_entry_data <= entry;
      do @(posedge clock); while (req_stall);
      sb.advance_walk(op, va, entry);
   endtask

   task automatic drain_and_write_base(input logic [31:0] base);
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= base;
      @(posedge clock);
      sb.table_base = base;
      csr_write_enable <= 1'b0;
      csr_write_data <= 32'($urandom);
   endtask

   task automatic random_walks(input int count);
      int done_items;
      int pick;
      logic op;
      logic [47:0] va;
      logic [31:0] entry;
      done_items = 0;
      while (done_items < count || sb.walk_busy) begin
         pick = $urandom_range(99);
         if (done_items >= count || pick < 88) begin
            op = sb.walk_busy ? ptw_pkg::OP_RESPONSE : ptw_pkg::OP_START;
         end else begin
            op = 1'($urandom_range(1));
         end
         va = {16'($urandom), 32'($urandom)};
         if ($urandom_range(19) == 0) begin
            va = $urandom_range(1) ? 48'hFFFF_FFFF_FFFF : 48'h0;
         end
         entry = 32'($urandom);
         if ($urandom_range(19) == 0) begin
            entry = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
         end
         done_items++;
         send_item(op, va, entry);
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_result_kind, rsp_address);
         end
         if (hold_off_request) begin
            hold_left = HoldCycles;
            hold_off_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(99) < IdlePercent);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QuietLimit) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("no transfer for %0d cycles, giving up", QuietLimit);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= ptw_pkg::OP_START;
      req_virtual_address <= '0;
      req_entry_data <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed walks with the reset table base: ignored items, both page
      // sizes, and all-zero and all-one addresses and entries.
      send_item(ptw_pkg::OP_RESPONSE, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      send_item(ptw_pkg::OP_START, 48'h0, 32'hFFFF_FFFF);
      send_item(ptw_pkg::OP_START, 48'hFFFF_FFFF_FFFF, 32'h0);
      send_item(ptw_pkg::OP_RESPONSE, 48'h0, 32'h0);
      send_item(ptw_pkg::OP_RESPONSE, 48'h0, 32'hFFFF_FFFF);
      send_item(ptw_pkg::OP_RESPONSE, 48'h0, 32'hFFFF_FFFF);
      send_item(ptw_pkg::OP_START, 48'hFFFF_FFFF_FFFF, 32'h0);
      send_item(ptw_pkg::OP_RESPONSE, 48'h0, 32'hFFFF_FFFF);
      send_item(ptw_pkg::OP_RESPONSE, 48'h0, 32'h0);
      send_item(ptw_pkg::OP_RESPONSE, 48'h0, 32'hFFFF_FF7F);
      send_item(ptw_pkg::OP_START, 48'h1234_5678_9ABC, 32'hFFFF_FFFF);
      send_item(ptw_pkg::OP_RESPONSE, 48'h0, 32'hFFFF_FFFF);
      send_item(ptw_pkg::OP_START, 48'h8000_0000_0000, 32'h0);
      send_item(ptw_pkg::OP_RESPONSE, 48'hFFFF_FFFF_FFFF, 32'h8000_0000);
      send_item(ptw_pkg::OP_RESPONSE, 48'hFFFF_FFFF_FFFF, 32'h0000_1000);
      send_item(ptw_pkg::OP_RESPONSE, 48'hFFFF_FFFF_FFFF, 32'h0000_0080);
      send_item(ptw_pkg::OP_RESPONSE, 48'h0, 32'h0000_0080);
      send_item(ptw_pkg::OP_START, 48'h0000_7FFF_FFFF, 32'h0);
      send_item(ptw_pkg::OP_RESPONSE, 48'h0, 32'h0);
      send_item(ptw_pkg::OP_RESPONSE, 48'h0, 32'h0);
      send_item(ptw_pkg::OP_RESPONSE, 48'h0, 32'h0);
      send_item(ptw_pkg::OP_RESPONSE, 48'h0, 32'hFFFF_F000);

      drain_and_write_base(32'hFFFF_FFFF);
      hold_off_request = 1'b1;
      random_walks(220);

      drain_and_write_base(32'h0000_0FFF);
      no_idle = 1'b1;
      random_walks(200);
      no_idle = 1'b0;

      drain_and_write_base(32'($urandom));
      random_walks(220);

      drain_and_write_base(32'hFFFF_F000);
      random_walks(200);

      drain_and_write_base(32'($urandom));
      random_walks(210);

      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Walks finished: %0d with 4 KiB pages, %0d with 2 MiB pages; %0d entry reads.",
               sb.small_pages, sb.large_pages, sb.reads_issued);
      $display("Out-of-turn items ignored: %0d; mismatches: %0d.",
               sb.ignored_items, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: page_table_walker.f
hw/rtl/ptw_pkg.sv
hw/rtl/ptw_input_stage.sv
hw/rtl/ptw_walk_core.sv
hw/rtl/ptw_output_stage.sv
hw/rtl/page_table_walker.sv
test/page_table_walker_test.sv
